// ===== hdl/bscpp_pkg.sv =====
package bscpp_pkg;

  // default curve size, log2 of the largest image side
  localparam int MaxDimLog2 = 10;

  // layout codes
  localparam logic [1:0] LAYOUT_HILBERT = 2'd0;
  localparam logic [1:0] LAYOUT_SWAPPED = 2'd1;
  localparam logic [1:0] LAYOUT_RASTER  = 2'd2;
  localparam logic [1:0] LAYOUT_SERPENT = 2'd3;

  // colour scheme codes
  localparam logic [1:0] SCHEME_CLASS  = 2'd0;
  localparam logic [1:0] SCHEME_GREY   = 2'd1;
  localparam logic [1:0] SCHEME_SCALED = 2'd2;

  // register indexes
  localparam logic [2:0] REG_LAYOUT = 3'd0;
  localparam logic [2:0] REG_SCHEME = 3'd1;
  localparam logic [2:0] REG_WIDTH  = 3'd2;
  localparam logic [2:0] REG_HEIGHT = 3'd3;
  localparam logic [2:0] REG_ASCII  = 3'd4;
  localparam logic [2:0] REG_LOW    = 3'd5;
  localparam logic [2:0] REG_HIGH   = 3'd6;
  localparam logic [2:0] REG_GAINS  = 3'd7;

  // register reset values
  localparam logic [10:0] RST_WIDTH  = 11'd256;
  localparam logic [10:0] RST_HEIGHT = 11'd256;
  localparam logic [23:0] RST_ASCII  = 24'h377eb8;
  localparam logic [23:0] RST_LOW    = 24'h4daf4a;
  localparam logic [23:0] RST_HIGH   = 24'he41a1c;
  localparam logic [23:0] RST_GAINS  = 24'hffffff;

  // byte classes
  localparam logic [7:0] BYTE_ZERO  = 8'h00;
  localparam logic [7:0] BYTE_ONES  = 8'hff;
  localparam logic [7:0] BYTE_SPACE = 8'h20;
  localparam logic [7:0] BYTE_DEL   = 8'h7f;
  localparam logic [7:0] BYTE_TAB   = 8'h09;
  localparam logic [7:0] BYTE_LF    = 8'h0a;
  localparam logic [7:0] BYTE_CR    = 8'h0d;

  typedef struct packed {
    logic [1:0]  layout;
    logic [1:0]  scheme;
    logic [10:0] width;
    logic [10:0] height;
    logic [23:0] ascii_rgb;
    logic [23:0] low_rgb;
    logic [23:0] high_rgb;
    logic [23:0] gains;
  } cfg_t;

  // per point control that travels along the cell chain
  typedef struct packed {
    logic       valid;
    logic       last;
    logic       raster;
    logic       ras_on;
    logic [7:0] data;
  } meta_t;

endpackage

// ===== hdl/bscpp_front.sv =====
module bscpp_front import bscpp_pkg::*; #(
  parameter int MAX_DIM_LOG2 = MaxDimLog2
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      accept_i,
  input  logic [7:0]                data_byte_i,
  input  logic                      frame_start_i,
  input  cfg_t                      cfg_i,
  input  logic [MAX_DIM_LOG2:0]     wdim_i,
  input  logic [MAX_DIM_LOG2:0]     hdim_i,
  output meta_t                     meta_o,
  output logic [MAX_DIM_LOG2-1:0]   x_o,
  output logic [MAX_DIM_LOG2-1:0]   y_o,
  output logic [2*MAX_DIM_LOG2-1:0] d_o
);

  localparam int DimW = MAX_DIM_LOG2 + 1;
  localparam int PcW  = 2 * MAX_DIM_LOG2 + 1;
  localparam int DW   = 2 * MAX_DIM_LOG2;
  localparam int TotW = 2 * DimW;

  logic [PcW-1:0]          pc_q, pc_d, pc_s;
  logic [MAX_DIM_LOG2-1:0] col_q, col_d, col_s;
  logic [DimW-1:0]         row_q, row_d, row_s;
  logic                    full_q, full_d, full_s;

  logic [TotW-1:0]         total;
  logic [TotW-1:0]         pc_inc;
  logic                    last;
  logic [DimW-1:0]         col_inc;
  logic                    col_wrap;
  logic                    ras_on;
  logic [DimW-1:0]         col_flip;
  logic [MAX_DIM_LOG2-1:0] ras_x;
  logic                    take;

  meta_t                   meta_q;
  logic [MAX_DIM_LOG2-1:0] x_q, y_q;
  logic [DW-1:0]           d_q;

  always_comb begin
    pc_s   = frame_start_i ? '0 : pc_q;
    col_s  = frame_start_i ? '0 : col_q;
    row_s  = frame_start_i ? '0 : row_q;
    full_s = frame_start_i ? 1'b0 : full_q;

    total    = TotW'(wdim_i) * TotW'(hdim_i);
    pc_inc   = TotW'(pc_s) + TotW'(1);
    last     = pc_inc >= total;
    col_inc  = DimW'(col_s) + DimW'(1);
    col_wrap = col_inc >= wdim_i;
    ras_on   = (DimW'(col_s) < wdim_i) && (row_s < hdim_i);
    col_flip = wdim_i - DimW'(1) - DimW'(col_s);
    ras_x    = ((cfg_i.layout == LAYOUT_SERPENT) && row_s[0]) ?
               col_flip[MAX_DIM_LOG2-1:0] : col_s;
    take     = accept_i && !full_s;

    pc_d   = pc_q;
    col_d  = col_q;
    row_d  = row_q;
    full_d = full_q;
    if (accept_i) begin
      pc_d   = pc_s;
      col_d  = col_s;
      row_d  = row_s;
      full_d = full_s;
      if (!full_s) begin
        pc_d   = pc_s + PcW'(1);
        full_d = last;
        if (col_wrap) begin
          col_d = '0;
          // saturate: a row this far out is off every image
          row_d = (&row_s) ? row_s : row_s + DimW'(1);
        end else begin
          col_d = col_inc[MAX_DIM_LOG2-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      col_q  <= '0;
      row_q  <= '0;
      full_q <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      col_q  <= col_d;
      row_q  <= row_d;
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_q <= '0;
    end else if (en_i) begin
      meta_q.valid  <= take;
      meta_q.last   <= last;
      meta_q.raster <= cfg_i.layout[1];
      meta_q.ras_on <= ras_on;
      meta_q.data   <= data_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= cfg_i.layout[1] ? ras_x : '0;
      y_q <= cfg_i.layout[1] ? row_s[MAX_DIM_LOG2-1:0] : '0;
      d_q <= pc_s[DW-1:0];
    end
  end

  assign meta_o = meta_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign d_o    = d_q;

endmodule

// ===== hdl/bscpp_curve_cell.sv =====
module bscpp_curve_cell import bscpp_pkg::*; #(
  parameter int MAX_DIM_LOG2 = MaxDimLog2,
  parameter int LEVEL        = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic [MAX_DIM_LOG2:0]     wdim_i,
  input  meta_t                     meta_i,
  input  logic [MAX_DIM_LOG2-1:0]   x_i,
  input  logic [MAX_DIM_LOG2-1:0]   y_i,
  input  logic [2*MAX_DIM_LOG2-1:0] d_i,
  output meta_t                     meta_o,
  output logic [MAX_DIM_LOG2-1:0]   x_o,
  output logic [MAX_DIM_LOG2-1:0]   y_o,
  output logic [2*MAX_DIM_LOG2-1:0] d_o
);

  localparam int DimW = MAX_DIM_LOG2 + 1;
  localparam logic [DimW-1:0] Side = DimW'(1) << LEVEL;
  localparam logic [MAX_DIM_LOG2-1:0] Mask = MAX_DIM_LOG2'((1 << LEVEL) - 1);

  logic                    active;
  logic                    rx, ry;
  logic [MAX_DIM_LOG2-1:0] xa, ya, x_d, y_d;

  meta_t                   meta_q;
  logic [MAX_DIM_LOG2-1:0] x_q, y_q;
  logic [2*MAX_DIM_LOG2-1:0] d_q;

  always_comb begin
    active = !meta_i.raster && (Side < wdim_i);
    rx     = d_i[2*LEVEL+1];
    ry     = d_i[2*LEVEL] ^ rx;
    xa     = x_i;
    ya     = y_i;
    if (!ry && rx) begin
      xa = x_i ^ Mask;
      ya = y_i ^ Mask;
    end
    x_d = x_i;
    y_d = y_i;
    if (active) begin
      x_d = ry ? xa : ya;
      y_d = ry ? ya : xa;
      x_d[LEVEL] = rx;
      y_d[LEVEL] = ry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_q <= '0;
    end else if (en_i) begin
      meta_q <= meta_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      d_q <= d_i;
    end
  end

  assign meta_o = meta_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign d_o    = d_q;

endmodule

// ===== hdl/bscpp_out_stage.sv =====
module bscpp_out_stage import bscpp_pkg::*; #(
  parameter int MAX_DIM_LOG2 = MaxDimLog2
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  cfg_t                    cfg_i,
  input  logic [MAX_DIM_LOG2:0]   wdim_i,
  input  logic [MAX_DIM_LOG2:0]   hdim_i,
  input  meta_t                   meta_i,
  input  logic [MAX_DIM_LOG2-1:0] x_i,
  input  logic [MAX_DIM_LOG2-1:0] y_i,
  output logic                    valid_o,
  output logic [9:0]              pixel_x_o,
  output logic [9:0]              pixel_y_o,
  output logic [7:0]              red_level_o,
  output logic [7:0]              green_level_o,
  output logic [7:0]              blue_level_o,
  output logic                    frame_last_o
);

  localparam int DimW = MAX_DIM_LOG2 + 1;

  logic [MAX_DIM_LOG2-1:0] px, py;
  logic                    on;
  logic [7:0]              b;
  logic                    is_ascii;
  logic [15:0]             r_mul, g_mul, b_mul;
  logic [23:0]             rgb;

  logic                    valid_q;
  logic [MAX_DIM_LOG2-1:0] px_q, py_q;
  logic [23:0]             rgb_q;
  logic                    last_q;

  always_comb begin
    px = (!meta_i.raster && (cfg_i.layout == LAYOUT_SWAPPED)) ? y_i : x_i;
    py = (!meta_i.raster && (cfg_i.layout == LAYOUT_SWAPPED)) ? x_i : y_i;
    on = meta_i.raster ? meta_i.ras_on :
         ((DimW'(px) < wdim_i) && (DimW'(py) < hdim_i));

    b        = meta_i.data;
    is_ascii = ((b >= BYTE_SPACE) && (b < BYTE_DEL)) ||
               (b == BYTE_LF) || (b == BYTE_CR) || (b == BYTE_TAB);
    r_mul    = 16'(b) * 16'(cfg_i.gains[23:16]);
    g_mul    = 16'(b) * 16'(cfg_i.gains[15:8]);
    b_mul    = 16'(b) * 16'(cfg_i.gains[7:0]);

    case (cfg_i.scheme)
      SCHEME_CLASS: begin
        if (b == BYTE_ZERO) begin
          rgb = 24'h000000;
        end else if (b == BYTE_ONES) begin
          rgb = 24'hffffff;
        end else if (is_ascii) begin
          rgb = cfg_i.ascii_rgb;
        end else if (b < BYTE_SPACE) begin
          rgb = cfg_i.low_rgb;
        end else begin
          rgb = cfg_i.high_rgb;
        end
      end
      SCHEME_GREY:   rgb = {b, b, b};
      SCHEME_SCALED: rgb = {r_mul[15:8], g_mul[15:8], b_mul[15:8]};
      default:       rgb = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= meta_i.valid && on;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q   <= px;
      py_q   <= py;
      rgb_q  <= rgb;
      last_q <= meta_i.last;
    end
  end

  assign valid_o       = valid_q;
  assign pixel_x_o     = 10'(px_q);
  assign pixel_y_o     = 10'(py_q);
  assign red_level_o   = rgb_q[23:16];
  assign green_level_o = rgb_q[15:8];
  assign blue_level_o  = rgb_q[7:0];
  assign frame_last_o  = last_q;

endmodule

// ===== hdl/byte_stream_curve_pixel_plotter_unit.sv =====
// a result passes the front-end register, the curve cell registers and the output register
// throughput: one input transaction per cycle; the pipeline only holds when the
//   output register is full and not being taken
// reset: rst_ni clears the point, column and row counters, the frame-full flag,
//   every stage valid bit and the registers to their default values
module byte_stream_curve_pixel_plotter_unit import bscpp_pkg::*; #(
  parameter int MAX_DIM_LOG2 = MaxDimLog2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_start_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [9:0]  pixel_x_o,
  output logic [9:0]  pixel_y_o,
  output logic [7:0]  red_level_o,
  output logic [7:0]  green_level_o,
  output logic [7:0]  blue_level_o,
  output logic        frame_last_o,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DimW = MAX_DIM_LOG2 + 1;
  // common width for clamping the 11-bit size registers
  localparam int ClW  = (DimW > 11) ? DimW : 11;
  localparam int DW   = 2 * MAX_DIM_LOG2;

  // ---------------------------------------------------------------------------
  // register file
  // ---------------------------------------------------------------------------
  cfg_t       cfg_q;
  logic [2:0] reg_idx;
  logic       reg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  // write lands on the access cycle
  assign reg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.layout    <= LAYOUT_HILBERT;
      cfg_q.scheme    <= SCHEME_CLASS;
      cfg_q.width     <= RST_WIDTH;
      cfg_q.height    <= RST_HEIGHT;
      cfg_q.ascii_rgb <= RST_ASCII;
      cfg_q.low_rgb   <= RST_LOW;
      cfg_q.high_rgb  <= RST_HIGH;
      cfg_q.gains     <= RST_GAINS;
    end else if (reg_wr) begin
      unique case (reg_idx)
        REG_LAYOUT: cfg_q.layout    <= pwdata[1:0];
        REG_SCHEME: cfg_q.scheme    <= pwdata[1:0];
        REG_WIDTH:  cfg_q.width     <= pwdata[10:0];
        REG_HEIGHT: cfg_q.height    <= pwdata[10:0];
        REG_ASCII:  cfg_q.ascii_rgb <= pwdata[23:0];
        REG_LOW:    cfg_q.low_rgb   <= pwdata[23:0];
        REG_HIGH:   cfg_q.high_rgb  <= pwdata[23:0];
        REG_GAINS:  cfg_q.gains     <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LAYOUT: prdata = 32'(cfg_q.layout);
      REG_SCHEME: prdata = 32'(cfg_q.scheme);
      REG_WIDTH:  prdata = 32'(cfg_q.width);
      REG_HEIGHT: prdata = 32'(cfg_q.height);
      REG_ASCII:  prdata = 32'(cfg_q.ascii_rgb);
      REG_LOW:    prdata = 32'(cfg_q.low_rgb);
      REG_HIGH:   prdata = 32'(cfg_q.high_rgb);
      REG_GAINS:  prdata = 32'(cfg_q.gains);
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // image size: zero reads as one, anything above the largest side saturates
  // ---------------------------------------------------------------------------
  logic [ClW-1:0]  w_ext, h_ext, w_cl, h_cl;
  logic [ClW-1:0]  dim_lim;
  logic [DimW-1:0] wdim, hdim;

  always_comb begin
    dim_lim = ClW'(1) << MAX_DIM_LOG2;
    w_ext   = ClW'(cfg_q.width);
    h_ext   = ClW'(cfg_q.height);
    w_cl    = (w_ext == '0) ? ClW'(1) : ((w_ext > dim_lim) ? dim_lim : w_ext);
    h_cl    = (h_ext == '0) ? ClW'(1) : ((h_ext > dim_lim) ? dim_lim : h_ext);
    wdim    = w_cl[DimW-1:0];
    hdim    = h_cl[DimW-1:0];
  end

  // ---------------------------------------------------------------------------
  // pipeline control: every stage moves together; a bubble moves like a point
  // ---------------------------------------------------------------------------
  logic advance;
  logic accept;

  assign advance    = !out_valid_o || out_ready_i;
  assign in_ready_o = advance;
  assign accept     = in_valid_i && in_ready_o;

  // stage 0 is the counter front end, stages 1..MAX_DIM_LOG2 are curve cells
  meta_t                   chain_meta [MAX_DIM_LOG2+1];
  logic [MAX_DIM_LOG2-1:0] chain_x    [MAX_DIM_LOG2+1];
  logic [MAX_DIM_LOG2-1:0] chain_y    [MAX_DIM_LOG2+1];
  logic [DW-1:0]           chain_d    [MAX_DIM_LOG2+1];

  // point counter, raster counters, frame-full flag and raster position
  bscpp_front #(
    .MAX_DIM_LOG2 (MAX_DIM_LOG2)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (advance),
    .accept_i      (accept),
    .data_byte_i   (data_byte_i),
    .frame_start_i (frame_start_i),
    .cfg_i         (cfg_q),
    .wdim_i        (wdim),
    .hdim_i        (hdim),
    .meta_o        (chain_meta[0]),
    .x_o           (chain_x[0]),
    .y_o           (chain_y[0]),
    .d_o           (chain_d[0])
  );

  // one cell per curve level: cell k folds point bits 2k+1:2k into x and y while its side
  // is below the image width, and leaves raster transactions untouched
  for (genvar k = 0; k < MAX_DIM_LOG2; k++) begin : g_cell
    bscpp_curve_cell #(
      .MAX_DIM_LOG2 (MAX_DIM_LOG2),
      .LEVEL        (k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (advance),
      .wdim_i (wdim),
      .meta_i (chain_meta[k]),
      .x_i    (chain_x[k]),
      .y_i    (chain_y[k]),
      .d_i    (chain_d[k]),
      .meta_o (chain_meta[k+1]),
      .x_o    (chain_x[k+1]),
      .y_o    (chain_y[k+1]),
      .d_o    (chain_d[k+1])
    );
  end

  // off-image check, x/y swap and colour, into the output register
  bscpp_out_stage #(
    .MAX_DIM_LOG2 (MAX_DIM_LOG2)
  ) u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (advance),
    .cfg_i         (cfg_q),
    .wdim_i        (wdim),
    .hdim_i        (hdim),
    .meta_i        (chain_meta[MAX_DIM_LOG2]),
    .x_i           (chain_x[MAX_DIM_LOG2]),
    .y_i           (chain_y[MAX_DIM_LOG2]),
    .valid_o       (out_valid_o),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .red_level_o   (red_level_o),
    .green_level_o (green_level_o),
    .blue_level_o  (blue_level_o),
    .frame_last_o  (frame_last_o)
  );

endmodule
